FILE: hdl/line_interpolator_3d_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line interpolator
// Shared property forms used by the modules that carry assertions.
// ---------------------------------------------------------------------------
`ifndef LINE_INTERPOLATOR_3D_TOP_DEFINES_SVH
`define LINE_INTERPOLATOR_3D_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LI3D_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("li3d assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define LI3D_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("li3d assertion failed");

`endif

FILE: hdl/li3d_pkg.sv
// ---------------------------------------------------------------------------
// Line interpolator package
// Widths, codes and transaction types shared by the interpolator modules.
// ---------------------------------------------------------------------------
package li3d_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int TWICE_WIDTH = COORD_WIDTH + 1;
  localparam int ERR_WIDTH   = COORD_WIDTH + 3;
  localparam int STEPS_WIDTH = COORD_WIDTH + 1;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic                          mode;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
  } item_t;

  // Bit 0 is x, bit 1 is y, bit 2 is z.
  typedef struct packed {
    logic [2:0]                    step;
    logic [2:0]                    dir;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic                          done;
    logic                          idle;
  } res_t;

endpackage

FILE: hdl/line_interpolator_3d_top.sv
// ---------------------------------------------------------------------------
// 3D line interpolator, top level
// Bresenham stepper that turns line endpoints into per-axis step pulses.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one transaction per
// command. A transaction with mode 0 loads a start and an end point and
// returns nothing; the position jumps to the start point at once. A
// transaction with mode 1 advances the line by one step and returns exactly
// one result transaction on the output channel (out_valid, out_stall) with
// the step and direction bits, the new position, done_res on the last step,
// and idle when no line is active. The accept rule is valid high, stall low.
// An accepted advance is registered in the core, then queued for output.
// Throughput is one transaction per cycle while the queue has room, set by
// the registered error term update in the core. Reset (rst, synchronous)
// empties the pipeline and zeroes position and line state, so the block is
// idle. When the receiver stalls, a two-entry result queue keeps absorbing
// work; once it is full, the input register holds its transaction and
// in_stall rises until the receiver takes a result.
// ---------------------------------------------------------------------------
module line_interpolator_3d_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    mode,
  input  logic signed [li3d_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [li3d_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [li3d_pkg::COORD_WIDTH-1:0] start_z,
  input  logic signed [li3d_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [li3d_pkg::COORD_WIDTH-1:0] end_y,
  input  logic signed [li3d_pkg::COORD_WIDTH-1:0] end_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    step_x,
  output logic                                    dir_x,
  output logic                                    step_y,
  output logic                                    dir_y,
  output logic                                    step_z,
  output logic                                    dir_z,
  output logic signed [li3d_pkg::COORD_WIDTH-1:0] pos_x,
  output logic signed [li3d_pkg::COORD_WIDTH-1:0] pos_y,
  output logic signed [li3d_pkg::COORD_WIDTH-1:0] pos_z,
  output logic                                    done_res,
  output logic                                    idle
);

  // The incoming transaction, gathered into one word for the core.
  li3d_pkg::item_t in_item;

  // Core to queue: one result per executed advance.
  logic           push;
  li3d_pkg::res_t push_data;
  logic           q_full;

  // Oldest queued result, shown on the output ports.
  li3d_pkg::res_t head;

  always_comb begin
    in_item.mode    = mode;
    in_item.start_x = start_x;
    in_item.start_y = start_y;
    in_item.start_z = start_z;
    in_item.end_x   = end_x;
    in_item.end_y   = end_y;
    in_item.end_z   = end_z;
  end

  // The core registers each transaction and applies it to the line state
  // once the result queue has room.
  li3d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // The result queue doubles as the output register, so out_valid is decoded
  // from the registered entry count and never depends on out_stall.
  li3d_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign step_x   = head.step[0];
  assign dir_x    = head.dir[0];
  assign step_y   = head.step[1];
  assign dir_y    = head.dir[1];
  assign step_z   = head.step[2];
  assign dir_z    = head.dir[2];
  assign pos_x    = head.pos_x;
  assign pos_y    = head.pos_y;
  assign pos_z    = head.pos_z;
  assign done_res = head.done;
  assign idle     = head.idle;

endmodule

FILE: hdl/li3d_core.sv
// ---------------------------------------------------------------------------
// Line interpolator core
// Input register, line state and the load and advance logic.
// ---------------------------------------------------------------------------
`include "line_interpolator_3d_top_defines.svh"

module li3d_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  li3d_pkg::item_t in_item,
  input  logic            q_full,
  output logic            push,
  output li3d_pkg::res_t  push_data
);

  localparam int CW = li3d_pkg::COORD_WIDTH;
  localparam int TW = li3d_pkg::TWICE_WIDTH;
  localparam int EW = li3d_pkg::ERR_WIDTH;
  localparam int SW = li3d_pkg::STEPS_WIDTH;

  // Input register.
  logic            s1_valid;
  li3d_pkg::item_t s1_item;

  // Line state.
  logic signed [CW-1:0] cur_x, cur_y, cur_z;
  logic [2:0]           axis_signs;
  li3d_pkg::axis_t      major_axis;
  logic [TW-1:0]        twice_major, twice_minor_a, twice_minor_b;
  logic signed [EW-1:0] err_a, err_b;
  logic [SW-1:0]        steps_left;

  logic fire, accept, is_load, is_adv, active;

  // Load path.
  logic signed [CW:0] diff_x, diff_y, diff_z, neg_x, neg_y, neg_z;
  logic [CW-1:0]      dx, dy, dz, dmaj, da, db;
  li3d_pkg::axis_t    load_axis;
  logic [2:0]         load_signs;

  // Advance path.
  logic                 ga, gb;
  logic [2:0]           stp;
  logic signed [EW-1:0] err_a_adv, err_b_adv;
  logic signed [CW-1:0] pos_x_adv, pos_y_adv, pos_z_adv;
  logic [SW-1:0]        steps_adv;

  assign fire     = s1_valid && !q_full;
  assign in_stall = s1_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign is_load  = (s1_item.mode == li3d_pkg::MODE_LOAD);
  assign is_adv   = (s1_item.mode == li3d_pkg::MODE_ADVANCE);
  assign active   = (steps_left != '0);

  always_comb begin
    diff_x = {s1_item.end_x[CW-1], s1_item.end_x} - {s1_item.start_x[CW-1], s1_item.start_x};
    diff_y = {s1_item.end_y[CW-1], s1_item.end_y} - {s1_item.start_y[CW-1], s1_item.start_y};
    diff_z = {s1_item.end_z[CW-1], s1_item.end_z} - {s1_item.start_z[CW-1], s1_item.start_z};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    neg_z  = -diff_z;
    dx = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
    dy = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];
    dz = diff_z[CW] ? neg_z[CW-1:0] : diff_z[CW-1:0];
    load_signs[0] = !diff_x[CW] && (diff_x != '0);
    load_signs[1] = !diff_y[CW] && (diff_y != '0);
    load_signs[2] = !diff_z[CW] && (diff_z != '0);
    // x wins ties, then y.
    priority if (dx >= dy && dx >= dz) begin
      load_axis = li3d_pkg::AXIS_X;
      dmaj = dx; da = dy; db = dz;
    end else if (dy >= dx && dy >= dz) begin
      load_axis = li3d_pkg::AXIS_Y;
      dmaj = dy; da = dx; db = dz;
    end else begin
      load_axis = li3d_pkg::AXIS_Z;
      dmaj = dz; da = dy; db = dx;
    end
  end

  always_comb begin
    ga = !err_a[EW-1];
    gb = !err_b[EW-1];
    unique case (major_axis)
      li3d_pkg::AXIS_X: stp = {gb, ga, 1'b1};
      li3d_pkg::AXIS_Y: stp = {gb, 1'b1, ga};
      default:          stp = {1'b1, ga, gb};
    endcase
    if (!active) begin
      stp = 3'b000;
    end
    err_a_adv = err_a - (ga ? {2'b00, twice_major} : '0) + {2'b00, twice_minor_a};
    err_b_adv = err_b - (gb ? {2'b00, twice_major} : '0) + {2'b00, twice_minor_b};
    pos_x_adv = stp[0] ? cur_x + (axis_signs[0] ? CW'(1) : {CW{1'b1}}) : cur_x;
    pos_y_adv = stp[1] ? cur_y + (axis_signs[1] ? CW'(1) : {CW{1'b1}}) : cur_y;
    pos_z_adv = stp[2] ? cur_z + (axis_signs[2] ? CW'(1) : {CW{1'b1}}) : cur_z;
    steps_adv = active ? steps_left - SW'(1) : steps_left;
  end

  assign push = fire && is_adv;

  always_comb begin
    push_data.step  = stp;
    push_data.dir   = stp & axis_signs;
    push_data.pos_x = pos_x_adv;
    push_data.pos_y = pos_y_adv;
    push_data.pos_z = pos_z_adv;
    push_data.done  = active && (steps_adv == '0);
    push_data.idle  = !active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      cur_z         <= '0;
      axis_signs    <= '0;
      major_axis    <= li3d_pkg::AXIS_X;
      twice_major   <= '0;
      twice_minor_a <= '0;
      twice_minor_b <= '0;
      err_a         <= '0;
      err_b         <= '0;
      steps_left    <= '0;
    end else if (fire && is_load) begin
      cur_x         <= s1_item.start_x;
      cur_y         <= s1_item.start_y;
      cur_z         <= s1_item.start_z;
      axis_signs    <= load_signs;
      major_axis    <= load_axis;
      twice_major   <= {dmaj, 1'b0};
      twice_minor_a <= {da, 1'b0};
      twice_minor_b <= {db, 1'b0};
      err_a         <= $signed({2'b00, da, 1'b0}) - $signed({3'b000, dmaj});
      err_b         <= $signed({2'b00, db, 1'b0}) - $signed({3'b000, dmaj});
      steps_left    <= {1'b0, dmaj};
    end else if (fire && is_adv && active) begin
      cur_x      <= pos_x_adv;
      cur_y      <= pos_y_adv;
      cur_z      <= pos_z_adv;
      err_a      <= err_a_adv;
      err_b      <= err_b_adv;
      steps_left <= steps_adv;
    end
  end

  `LI3D_ASSERT_IMP(a_idle_no_step, push && !active, push_data.idle && push_data.step == 3'b000)
  `LI3D_ASSERT_NXT(a_count_down, push && active, steps_left == $past(steps_left) - SW'(1))
  `LI3D_ASSERT_NXT(a_done_empties, push && push_data.done, steps_left == '0)

endmodule

FILE: hdl/li3d_res_fifo.sv
// ---------------------------------------------------------------------------
// Line interpolator result queue
// Two-entry queue that decouples the core from a stalling receiver.
// ---------------------------------------------------------------------------
`include "line_interpolator_3d_top_defines.svh"

module li3d_res_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  li3d_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output li3d_pkg::res_t head
);

  li3d_pkg::res_t ent [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count, count_next;
  logic           pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = ent[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  `LI3D_ASSERT_IMP(a_count_range, 1'b1, count <= 2'd2)
  `LI3D_ASSERT_IMP(a_no_overflow, push, !full)
  `LI3D_ASSERT_NXT(a_pop_drains, pop && !push, count == $past(count) - 2'd1)

endmodule

FILE: sim/tb_line_interpolator_3d_top.sv
// ---------------------------------------------------------------------------
// Testbench for the 3D line interpolator
// Loads and advances are driven through the valid/stall input channel.
// Every accepted transaction updates a local Bresenham tracker, which
// predicts each step result. Results from the output channel are compared
// field by field, in order, against those predictions. Both channels idle
// and stall at random, with quiet stretches between the busy ones.
// ---------------------------------------------------------------------------
module tb_line_interpolator_3d_top;

  localparam int CW       = li3d_pkg::COORD_WIDTH;
  localparam int WW       = CW + 3;
  localparam int LW       = CW + 1;
  localparam int CMIN     = -(1 << (CW - 1));
  localparam int CMAX     = (1 << (CW - 1)) - 1;
  localparam int N_ITEMS  = 1150;
  localparam int LIMIT    = 400000;
  localparam int TAIL     = 10;

  typedef struct {
    li3d_pkg::item_t cmd;
    bit              drain;
  } pend_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 mode = li3d_pkg::MODE_LOAD;
  logic signed [CW-1:0] start_x = '0;
  logic signed [CW-1:0] start_y = '0;
  logic signed [CW-1:0] start_z = '0;
  logic signed [CW-1:0] end_x = '0;
  logic signed [CW-1:0] end_y = '0;
  logic signed [CW-1:0] end_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 step_x, dir_x, step_y, dir_y, step_z, dir_z;
  logic signed [CW-1:0] pos_x, pos_y, pos_z;
  logic                 done_res;
  logic                 idle;

  line_interpolator_3d_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .step_x(step_x), .dir_x(dir_x),
    .step_y(step_y), .dir_y(dir_y),
    .step_z(step_z), .dir_z(dir_z),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .done_res(done_res), .idle(idle)
  );

  // Commands waiting to be driven, and the step results predicted for the
  // advance transactions that the block has already accepted.
  pend_t          pending_cmds[$];
  li3d_pkg::res_t expected_steps[$];
  bit             drain_next = 1'b0;

  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  // Bresenham tracker. Its reset values match the block after reset: the
  // position at the origin and no line active.
  logic signed [CW-1:0] trk_x = '0, trk_y = '0, trk_z = '0;
  logic [2:0]           trk_sign = '0;
  li3d_pkg::axis_t      trk_major = li3d_pkg::AXIS_X;
  logic signed [CW+2:0] dbl_major = '0, dbl_minor_a = '0, dbl_minor_b = '0;
  logic signed [CW+2:0] err_a = '0, err_b = '0;
  logic [CW:0]          trk_left = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // A load takes effect at once: the position jumps to the start point and
  // any line still in progress is dropped.
  function automatic void load_line(input li3d_pkg::item_t it);
    logic signed [CW+2:0] sx, sy, sz, ex, ey, ez, dx, dy, dz, dmaj, da, db;
    sx = WW'(it.start_x);
    sy = WW'(it.start_y);
    sz = WW'(it.start_z);
    ex = WW'(it.end_x);
    ey = WW'(it.end_y);
    ez = WW'(it.end_z);
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    dz = (ez > sz) ? ez - sz : sz - ez;
    // An axis whose end is not above its start counts as negative.
    trk_sign = {ez > sz, ey > sy, ex > sx};
    // Largest delta wins; x wins ties, then y. The minor axes are named a
    // and b: y,z for major x; x,z for major y; y,x for major z.
    if (dx >= dy && dx >= dz) begin
      trk_major = li3d_pkg::AXIS_X;
      dmaj = dx; da = dy; db = dz;
    end else if (dy >= dx && dy >= dz) begin
      trk_major = li3d_pkg::AXIS_Y;
      dmaj = dy; da = dx; db = dz;
    end else begin
      trk_major = li3d_pkg::AXIS_Z;
      dmaj = dz; da = dy; db = dx;
    end
    dbl_major   = dmaj + dmaj;
    dbl_minor_a = da + da;
    dbl_minor_b = db + db;
    err_a       = da + da - dmaj;
    err_b       = db + db - dmaj;
    trk_left    = dmaj[CW:0];
    trk_x = it.start_x;
    trk_y = it.start_y;
    trk_z = it.start_z;
  endfunction

  function automatic void move_axis(input li3d_pkg::axis_t a, inout li3d_pkg::res_t r);
    r.step[a] = 1'b1;
    r.dir[a]  = trk_sign[a];
    case (a)
      li3d_pkg::AXIS_X: trk_x = trk_sign[a] ? trk_x + CW'(1) : trk_x - CW'(1);
      li3d_pkg::AXIS_Y: trk_y = trk_sign[a] ? trk_y + CW'(1) : trk_y - CW'(1);
      default: trk_z = trk_sign[a] ? trk_z + CW'(1) : trk_z - CW'(1);
    endcase
  endfunction

  function automatic li3d_pkg::res_t advance_line();
    li3d_pkg::res_t  r;
    li3d_pkg::axis_t ax_a, ax_b;
    r = '0;
    case (trk_major)
      li3d_pkg::AXIS_X: begin
        ax_a = li3d_pkg::AXIS_Y;
        ax_b = li3d_pkg::AXIS_Z;
      end
      li3d_pkg::AXIS_Y: begin
        ax_a = li3d_pkg::AXIS_X;
        ax_b = li3d_pkg::AXIS_Z;
      end
      default: begin
        ax_a = li3d_pkg::AXIS_Y;
        ax_b = li3d_pkg::AXIS_X;
      end
    endcase
    if (trk_left == 0) begin
      // No line active: nothing moves and the result reports idle.
      r.idle = 1'b1;
    end else begin
      move_axis(trk_major, r);
      if (err_a >= 0) begin
        move_axis(ax_a, r);
        err_a = err_a - dbl_major;
      end
      if (err_b >= 0) begin
        move_axis(ax_b, r);
        err_b = err_b - dbl_major;
      end
      err_a    = err_a + dbl_minor_a;
      err_b    = err_b + dbl_minor_b;
      trk_left = trk_left - LW'(1);
      r.done   = (trk_left == 0);
    end
    r.pos_x = trk_x;
    r.pos_y = trk_y;
    r.pos_z = trk_z;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus construction
  // -------------------------------------------------------------------------

  function automatic li3d_pkg::item_t load_cmd(input int sx, input int sy, input int sz,
                                               input int ex, input int ey, input int ez);
    li3d_pkg::item_t it;
    it.mode    = li3d_pkg::MODE_LOAD;
    it.start_x = sx[CW-1:0];
    it.start_y = sy[CW-1:0];
    it.start_z = sz[CW-1:0];
    it.end_x   = ex[CW-1:0];
    it.end_y   = ey[CW-1:0];
    it.end_z   = ez[CW-1:0];
    return it;
  endfunction

  // The coordinate fields of an advance are ignored, so they carry noise.
  function automatic li3d_pkg::item_t advance_cmd();
    li3d_pkg::item_t it;
    it.mode    = li3d_pkg::MODE_ADVANCE;
    it.start_x = CW'($urandom());
    it.start_y = CW'($urandom());
    it.start_z = CW'($urandom());
    it.end_x   = CW'($urandom());
    it.end_y   = CW'($urandom());
    it.end_z   = CW'($urandom());
    return it;
  endfunction

  function automatic void push_cmd(input li3d_pkg::item_t it);
    pend_t p;
    p.cmd   = it;
    p.drain = drain_next;
    drain_next = 1'b0;
    pending_cmds.push_back(p);
  endfunction

  function automatic void push_advances(input int n);
    repeat (n) push_cmd(advance_cmd());
  endfunction

  // Mostly random over the whole range, with the two extremes favored.
  function automatic int coord_pick();
    case ($urandom_range(0, 7))
      0: return CMIN;
      1: return CMAX;
      default: return int'($urandom_range(0, (1 << CW) - 1)) + CMIN;
    endcase
  endfunction

  // A short line anywhere in the coordinate space, followed by advances:
  // usually exactly enough to finish it, sometimes too few (the next load
  // cuts it short) and sometimes a few more (advances while idle).
  function automatic void queue_line(input int dmax);
    int s[3];
    int e[3];
    int a, d, dmaj, n;
    dmaj = 0;
    for (a = 0; a < 3; a++) begin
      s[a] = coord_pick();
      d = $urandom_range(0, dmax);
      e[a] = $urandom_range(0, 1) ? s[a] + d : s[a] - d;
      if (e[a] > CMAX || e[a] < CMIN) e[a] = 2 * s[a] - e[a];
      if (d > dmaj) dmaj = d;
    end
    push_cmd(load_cmd(s[0], s[1], s[2], e[0], e[1], e[2]));
    case ($urandom_range(0, 5))
      0: n = $urandom_range(0, dmaj);
      1: n = dmaj + $urandom_range(1, 3);
      default: n = dmaj;
    endcase
    push_advances(n);
  endfunction

  // Draws the wait before the next transaction. Waits come in stretches:
  // some stretches never wait, the others draw a random wait per item.
  function automatic int draw_wait(inout int left, inout bit quiet);
    if (left == 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      left  = $urandom_range(8, 40);
    end
    left--;
    return quiet ? 0 : int'($urandom_range(0, 18));
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  function automatic void fail_note(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want)
      fail_note($sformatf("result %0d: %s expected %0h, got %0h",
                          results_seen, name, want, got));
  endfunction

  function automatic void check_step();
    li3d_pkg::res_t want;
    if (expected_steps.size() == 0) begin
      fail_note($sformatf("result %0d arrived with no advance waiting for it",
                          results_seen));
    end else begin
      want = expected_steps.pop_front();
      cmp_field("step", 32'(want.step), 32'({step_z, step_y, step_x}));
      cmp_field("dir", 32'(want.dir), 32'({dir_z, dir_y, dir_x}));
      cmp_field("pos_x", 32'(want.pos_x), 32'(pos_x));
      cmp_field("pos_y", 32'(want.pos_y), 32'(pos_y));
      cmp_field("pos_z", 32'(want.pos_z), 32'(pos_z));
      cmp_field("done_res", 32'(want.done), 32'(done_res));
      cmp_field("idle", 32'(want.idle), 32'(idle));
    end
    results_seen++;
  endfunction

  // -------------------------------------------------------------------------
  // Driver. A transaction on the input channel completes at an edge where
  // in_valid is high and in_stall is low; the tracker takes it at that
  // edge. While the block stalls, the ports hold their transaction. A
  // command flagged for draining is held back until every predicted result
  // has been received.
  // -------------------------------------------------------------------------
  li3d_pkg::item_t on_port;
  pend_t           next_cmd;
  int              tx_wait = 0;
  int              tx_left = 0;
  bit              tx_quiet = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (on_port.mode == li3d_pkg::MODE_LOAD) load_line(on_port);
        else expected_steps.push_back(advance_line());
      end
      if (tx_wait != 0) begin
        tx_wait  <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain && expected_steps.size() != 0)) begin
        next_cmd = pending_cmds.pop_front();
        on_port  = next_cmd.cmd;
        mode     <= on_port.mode;
        start_x  <= on_port.start_x;
        start_y  <= on_port.start_y;
        start_z  <= on_port.start_z;
        end_x    <= on_port.end_x;
        end_y    <= on_port.end_y;
        end_z    <= on_port.end_z;
        in_valid <= 1'b1;
        tx_wait  <= draw_wait(tx_left, tx_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor. A result transaction completes at an edge where out_valid is
  // high and out_stall is low. After each one the receiver draws how long
  // it stalls before it takes the next.
  // -------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_left = 0;
  bit rx_quiet = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_step();
        rx_wait = draw_wait(rx_left, rx_quiet);
      end else if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_line_interpolator_3d_top failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin
    int pick;
    bit drained;
    drained = 1'b0;

    // Directed part. First an advance straight out of reset, which must
    // report idle at the origin.
    push_advances(1);
    // Full-scale line: x runs from the lowest to the highest coordinate, y
    // the opposite way with the same delta (x wins the tie), z stays put.
    push_cmd(load_cmd(CMIN, CMAX, CMIN, CMAX, CMIN, CMIN));
    push_advances(2);
    // Three-way tie, run to the end and one advance past it.
    push_cmd(load_cmd(0, 0, 0, 3, -3, 3));
    push_advances(4);
    // y and z tie above x: y must be the major axis.
    push_cmd(load_cmd(0, 0, 0, 1, 5, -5));
    push_advances(2);
    // z major over the full range, x stepping down, y unchanged.
    push_cmd(load_cmd(CMAX, CMAX, CMIN, CMAX - 1, CMAX, CMAX));
    push_advances(2);
    // Empty line: start equal to end leaves the block idle at the start.
    push_cmd(load_cmd(7, -7, CMAX, 7, -7, CMAX));
    push_advances(1);
    // Load on top of a line in progress.
    push_cmd(load_cmd(0, 0, 0, 10, 4, 2));
    push_advances(1);
    push_cmd(load_cmd(-5, -5, -5, -8, -1, -5));
    push_advances(2);

    // Random part, mostly well-formed lines with random content.
    while (pending_cmds.size() < N_ITEMS) begin
      if (!drained && pending_cmds.size() >= N_ITEMS / 2) begin
        // Once, the sender waits for every outstanding result.
        drain_next = 1'b1;
        drained    = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 56) begin
        queue_line(12);
      end else if (pick < 70) begin
        queue_line(40);
      end else if (pick < 80) begin
        push_cmd(load_cmd(coord_pick(), coord_pick(), coord_pick(),
                          coord_pick(), coord_pick(), coord_pick()));
        push_advances($urandom_range(1, 8));
      end else if (pick < 90) begin
        push_advances($urandom_range(1, 4));
      end else begin
        push_cmd(load_cmd(coord_pick(), coord_pick(), coord_pick(),
                          coord_pick(), coord_pick(), coord_pick()));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Checked away from the active edge so the driver and the monitor have
    // settled for this cycle.
    while (pending_cmds.size() != 0 || in_valid || expected_steps.size() != 0)
      @(negedge clk);
    // The TAIL wait catches any stray result the block might still emit.
    repeat (TAIL) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_line_interpolator_3d_top passed");
    end else begin
      $display("tb_line_interpolator_3d_top failed");
    end
    $finish;
  end

endmodule
